FILE: rtl/rtq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rtq_pkg: shared types and constants for the resistive touch qualifier
// Field widths, configuration layout, register indexes, reset values, states.
// ----------------------------------------------------------------------------
package rtq_pkg;

	localparam int unsigned RAW_W     = 13;
	localparam int unsigned PT_W      = 16;
	localparam int unsigned CFG_W     = 17;
	localparam int unsigned CFG_IDX_W = 3;

	typedef struct packed {
		logic [1:0]         orientation;
		logic signed [16:0] x_gain;
		logic signed [16:0] y_gain;
		logic signed [10:0] x_offset;
		logic signed [10:0] y_offset;
		logic [11:0]        screen_width;
		logic [11:0]        screen_height;
		logic [12:0]        agree_tolerance;
	} rtq_cfg_t;

	typedef struct packed {
		logic               agreed;
		logic signed [15:0] point_x;
		logic signed [15:0] point_y;
	} rtq_fix_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LANE,
		ST_MERGE
	} rtq_state_t;

	localparam logic [CFG_IDX_W-1:0] REG_ORIENTATION = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_X_GAIN      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_Y_GAIN      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_X_OFFSET    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_Y_OFFSET    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_W    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_H    = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_AGREE_TOL   = 3'd7;

	localparam logic [1:0]         RST_ORIENTATION = 2'd1;
	localparam logic signed [16:0] RST_X_GAIN      = 17'sd5878;
	localparam logic signed [16:0] RST_Y_GAIN      = 17'sd8834;
	localparam logic signed [10:0] RST_X_OFFSET    = -11'sd21;
	localparam logic signed [10:0] RST_Y_OFFSET    = -11'sd39;
	localparam logic [11:0]        RST_SCREEN_W    = 12'd480;
	localparam logic [11:0]        RST_SCREEN_H    = 12'd320;
	localparam logic [12:0]        RST_AGREE_TOL   = 13'd50;

endpackage
`default_nettype wire

FILE: rtl/rtq_sample_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rtq_sample_if: raw touch sample channel
// Carries pen state and one raw X/Y conversion pair per request.
// ----------------------------------------------------------------------------
interface rtq_sample_if import rtq_pkg::*;;
	logic             valid;
	logic             ready;
	logic             pen_down;
	logic [RAW_W-1:0] x_raw;
	logic [RAW_W-1:0] y_raw;

	modport source (output valid, output pen_down, output x_raw, output y_raw, input ready);
	modport sink   (input valid, input pen_down, input x_raw, input y_raw, output ready);
endinterface
`default_nettype wire

FILE: rtl/rtq_point_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rtq_point_if: screen point channel
// Carries the held screen point, press state and agreement flag per request.
// ----------------------------------------------------------------------------
interface rtq_point_if import rtq_pkg::*;;
	logic                   valid;
	logic                   ready;
	logic signed [PT_W-1:0] point_x;
	logic signed [PT_W-1:0] point_y;
	logic                   pressed;
	logic                   agreed;

	modport source (output valid, output point_x, output point_y, output pressed,
		output agreed, input ready);
	modport sink   (input valid, input point_x, input point_y, input pressed,
		input agreed, output ready);
endinterface
`default_nettype wire

FILE: rtl/resistive_touch_qualifier.sv
`default_nettype none
// ----------------------------------------------------------------------------
// resistive_touch_qualifier: resistive touch sample qualifier
// Collects two rounds of raw X/Y pairs while the pen is down, takes a trimmed
// mean per axis in two lanes, checks agreement and calibrates a screen point.
// ----------------------------------------------------------------------------
//  channel     dir  handshake              payload
//  sample_in   in   valid/ready            pen_down, x_raw, y_raw
//  point_out   out  valid/ready            point_x, point_y, pressed, agreed
//  cfg         in   cfg_we (no wait)       cfg_index, cfg_data
//
//  A pen-up or mid-round request needs no further work. A request that ends a
//  round holds the input while both lanes rank one sample per cycle and run
//  the reciprocal multiply; the second round also runs the calibration
//  pipeline. Reset clears the press state, the count, the held point and loads
//  the default calibration. A stalled output holds the input unless the result
//  is taken in the same cycle.
// ----------------------------------------------------------------------------
module resistive_touch_qualifier import rtq_pkg::*; #(
	parameter int unsigned SAMPLES_PER_ROUND = 5,
	parameter int unsigned DROP_EACH_END     = 1
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	rtq_sample_if.sink                sample_in,
	rtq_point_if.source               point_out,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data
);
	localparam int unsigned N    = SAMPLES_PER_ROUND;
	localparam int unsigned DROP = (2 * DROP_EACH_END >= N) ? (N - 1) / 2 : DROP_EACH_END;
	localparam int unsigned IW   = $clog2(N);

	rtq_cfg_t   cfg_q;
	rtq_state_t state_q, state_nxt;
	logic [IW-1:0] pos_q;
	logic       second_q;
	logic       end_second_q;
	logic       press_q;
	logic [RAW_W-1:0] first_x_q, first_y_q;
	logic signed [PT_W-1:0] held_x_q, held_y_q;
	logic       out_valid_q;
	logic signed [PT_W-1:0] out_x_q, out_y_q;
	logic       out_pressed_q, out_agreed_q;

	logic       accept, pen, last_pos, pop;
	logic       in_ready, lane_start, merge_start, first_load;
	logic       x_done, y_done, merge_done;
	logic [RAW_W-1:0] x_mean, y_mean;
	rtq_fix_t   fix;

	assign pen      = sample_in.pen_down;
	assign accept   = sample_in.valid && in_ready;
	assign last_pos = (pos_q == IW'(N - 1));
	assign pop      = out_valid_q && point_out.ready;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && pen && last_pos) begin
					state_nxt = ST_LANE;
				end
			end
			ST_LANE: begin
				if (x_done) begin
					state_nxt = end_second_q ? ST_MERGE : ST_IDLE;
				end
			end
			ST_MERGE: begin
				if (merge_done) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready    = 1'b0;
		lane_start  = 1'b0;
		merge_start = 1'b0;
		first_load  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready   = !out_valid_q || point_out.ready;
				lane_start = sample_in.valid && in_ready && pen && last_pos;
			end
			ST_LANE: begin
				merge_start = x_done && end_second_q;
				first_load  = x_done && !end_second_q;
			end
			ST_MERGE: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.orientation     <= RST_ORIENTATION;
			cfg_q.x_gain          <= RST_X_GAIN;
			cfg_q.y_gain          <= RST_Y_GAIN;
			cfg_q.x_offset        <= RST_X_OFFSET;
			cfg_q.y_offset        <= RST_Y_OFFSET;
			cfg_q.screen_width    <= RST_SCREEN_W;
			cfg_q.screen_height   <= RST_SCREEN_H;
			cfg_q.agree_tolerance <= RST_AGREE_TOL;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ORIENTATION: cfg_q.orientation     <= cfg_data[1:0];
				REG_X_GAIN:      cfg_q.x_gain          <= $signed(cfg_data[16:0]);
				REG_Y_GAIN:      cfg_q.y_gain          <= $signed(cfg_data[16:0]);
				REG_X_OFFSET:    cfg_q.x_offset        <= $signed(cfg_data[10:0]);
				REG_Y_OFFSET:    cfg_q.y_offset        <= $signed(cfg_data[10:0]);
				REG_SCREEN_W:    cfg_q.screen_width    <= cfg_data[11:0];
				REG_SCREEN_H:    cfg_q.screen_height   <= cfg_data[11:0];
				REG_AGREE_TOL:   cfg_q.agree_tolerance <= cfg_data[12:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			pos_q        <= '0;
			second_q     <= 1'b0;
			end_second_q <= 1'b0;
			press_q      <= 1'b0;
			first_x_q    <= '0;
			first_y_q    <= '0;
			held_x_q     <= '0;
			held_y_q     <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (accept) begin
				if (!pen) begin
					press_q  <= 1'b0;
					pos_q    <= '0;
					second_q <= 1'b0;
				end else begin
					press_q <= 1'b1;
					if (last_pos) begin
						pos_q        <= '0;
						end_second_q <= second_q;
						second_q     <= !second_q;
					end else begin
						pos_q <= pos_q + IW'(1);
					end
				end
			end
			if (first_load) begin
				first_x_q <= x_mean;
				first_y_q <= y_mean;
			end
			if (merge_done && fix.agreed) begin
				held_x_q <= fix.point_x;
				held_y_q <= fix.point_y;
			end
			if ((accept && !pen) || merge_done) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !pen) begin
			out_x_q       <= held_x_q;
			out_y_q       <= held_y_q;
			out_pressed_q <= 1'b0;
			out_agreed_q  <= 1'b0;
		end else if (merge_done) begin
			out_x_q       <= fix.agreed ? fix.point_x : held_x_q;
			out_y_q       <= fix.agreed ? fix.point_y : held_y_q;
			out_pressed_q <= press_q;
			out_agreed_q  <= fix.agreed;
		end
	end

	rtq_lane #(.N(N), .DROP(DROP)) u_lane_x (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (accept && pen),
		.wr_addr (pos_q),
		.wr_data (sample_in.x_raw),
		.start   (lane_start),
		.done    (x_done),
		.mean    (x_mean)
	);

	rtq_lane #(.N(N), .DROP(DROP)) u_lane_y (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (accept && pen),
		.wr_addr (pos_q),
		.wr_data (sample_in.y_raw),
		.start   (lane_start),
		.done    (y_done),
		.mean    (y_mean)
	);

	rtq_merge u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (merge_start && y_done),
		.cfg      (cfg_q),
		.first_x  (first_x_q),
		.first_y  (first_y_q),
		.second_x (x_mean),
		.second_y (y_mean),
		.done     (merge_done),
		.fix      (fix)
	);

	assign sample_in.ready   = in_ready;
	assign point_out.valid   = out_valid_q;
	assign point_out.point_x = out_x_q;
	assign point_out.point_y = out_y_q;
	assign point_out.pressed = out_pressed_q;
	assign point_out.agreed  = out_agreed_q;

endmodule
`default_nettype wire

FILE: rtl/rtq_lane.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rtq_lane: one-axis sample window and trimmed mean
// Stores one round of samples, ranks one sample per cycle, sums the middle
// ranks and divides by the kept count through a reciprocal multiply.
// ----------------------------------------------------------------------------
module rtq_lane import rtq_pkg::*; #(
	parameter int unsigned N    = 5,
	parameter int unsigned DROP = 1
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(N)-1:0]     wr_addr,
	input  wire logic [RAW_W-1:0]         wr_data,
	input  wire logic                     start,
	output logic                          done,
	output logic [RAW_W-1:0]              mean
);
	localparam int unsigned IW    = $clog2(N);
	localparam int unsigned RW    = $clog2(N + 1);
	localparam int unsigned SW    = RAW_W + $clog2(N);
	localparam int unsigned KEEP  = N - 2 * DROP;
	localparam int unsigned SHIFT = SW + 4;
	localparam int unsigned MW    = SHIFT + 1;
	localparam int unsigned PW    = SW + MW;
	localparam logic [MW-1:0] RECIP = MW'((64'd1 << SHIFT) / KEEP + 64'd1);

	logic [RAW_W-1:0] win_q [N];
	logic             busy_q;
	logic [IW-1:0]    idx_q;
	logic [SW-1:0]    acc_q;
	logic             sum_v_q;
	logic [PW-1:0]    prod_s1;
	logic             prod_v_s1;
	logic             done_q;
	logic [RAW_W-1:0] mean_q;

	logic [RAW_W-1:0] cand;
	logic [RW-1:0]    rank;
	logic             keep;
	logic             last;

	always_comb begin
		cand = win_q[idx_q];
		rank = '0;
		for (int j = 0; j < int'(N); j++) begin
			if ((win_q[IW'(j)] < cand) || ((win_q[IW'(j)] == cand) && (IW'(j) < idx_q))) begin
				rank = rank + RW'(1);
			end
		end
		keep = (rank >= RW'(DROP)) && (rank < RW'(N - DROP));
		last = (idx_q == IW'(N - 1));
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			win_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			idx_q     <= '0;
			sum_v_q   <= 1'b0;
			prod_v_s1 <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			sum_v_q   <= busy_q && last;
			prod_v_s1 <= sum_v_q;
			done_q    <= prod_v_s1;
			if (start) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else if (busy_q) begin
				if (last) begin
					busy_q <= 1'b0;
				end else begin
					idx_q <= idx_q + IW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= acc_q + (keep ? SW'(cand) : SW'(0));
		end
		if (sum_v_q) begin
			prod_s1 <= PW'(acc_q) * PW'(RECIP);
		end
		if (prod_v_s1) begin
			mean_q <= prod_s1[SHIFT +: RAW_W];
		end
	end

	assign done = done_q;
	assign mean = mean_q;

endmodule
`default_nettype wire

FILE: rtl/rtq_merge.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rtq_merge: round agreement and screen calibration
// Checks both axes against the tolerance, averages the rounds, applies swap,
// Q16 gain, offset and mirroring, then truncates and saturates.
// ----------------------------------------------------------------------------
module rtq_merge import rtq_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire rtq_cfg_t         cfg,
	input  wire logic [RAW_W-1:0] first_x,
	input  wire logic [RAW_W-1:0] first_y,
	input  wire logic [RAW_W-1:0] second_x,
	input  wire logic [RAW_W-1:0] second_y,
	output logic                  done,
	output rtq_fix_t              fix
);
	localparam int unsigned VW = 34;

	logic               v_s1, v_s2, v_s3, v_s4;
	logic               agree_s1, agree_s2, agree_s3;
	logic [RAW_W-1:0]   mx_s1, my_s1;
	logic signed [30:0] px_s2, py_s2;
	logic signed [VW-1:0] vx_s3, vy_s3;
	rtq_fix_t           fix_s4;

	logic [RAW_W-1:0]   dx, dy, ax, ay;
	logic [RAW_W:0]     sx, sy;
	logic               agree;
	logic signed [VW-1:0] vx, vy;
	logic signed [PT_W-1:0] qx, qy;

	function automatic logic signed [PT_W-1:0] trunc_sat(input logic signed [VW-1:0] v);
		logic signed [VW-1:0] t;
		logic signed [VW-1:0] q;
		t = v[VW-1] ? (v + VW'(65535)) : v;
		q = t >>> 16;
		if (q > 34'sd32767) begin
			return 16'sd32767;
		end else if (q < -34'sd32768) begin
			return -16'sd32768;
		end
		return q[PT_W-1:0];
	endfunction

	function automatic logic signed [VW-1:0] place(input logic signed [30:0] p,
		input logic signed [10:0] off, input logic [11:0] size, input logic mirror);
		logic signed [VW-1:0] v;
		v = {{3{p[30]}}, p} + {{7{off[10]}}, off, 16'b0};
		if (mirror) begin
			v = $signed({6'b0, size, 16'b0}) - v;
		end
		return v;
	endfunction

	always_comb begin
		dx    = (first_x > second_x) ? (first_x - second_x) : (second_x - first_x);
		dy    = (first_y > second_y) ? (first_y - second_y) : (second_y - first_y);
		agree = (dx < cfg.agree_tolerance) && (dy < cfg.agree_tolerance);
		sx    = {1'b0, first_x} + {1'b0, second_x};
		sy    = {1'b0, first_y} + {1'b0, second_y};
		ax    = sx[RAW_W:1];
		ay    = sy[RAW_W:1];
		vx    = place(px_s2, cfg.x_offset, cfg.screen_width, cfg.orientation[0]);
		vy    = place(py_s2, cfg.y_offset, cfg.screen_height, cfg.orientation[0]);
		qx    = trunc_sat(vx_s3);
		qy    = trunc_sat(vy_s3);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			agree_s1 <= agree;
			mx_s1    <= cfg.orientation[1] ? ay : ax;
			my_s1    <= cfg.orientation[1] ? ax : ay;
		end
		if (v_s1) begin
			agree_s2 <= agree_s1;
			px_s2    <= 31'(cfg.x_gain) * 31'($signed({1'b0, mx_s1}));
			py_s2    <= 31'(cfg.y_gain) * 31'($signed({1'b0, my_s1}));
		end
		if (v_s2) begin
			agree_s3 <= agree_s2;
			vx_s3    <= vx;
			vy_s3    <= vy;
		end
		if (v_s3) begin
			fix_s4.agreed  <= agree_s3;
			fix_s4.point_x <= qx;
			fix_s4.point_y <= qy;
		end
	end

	assign done = v_s4;
	assign fix  = fix_s4;

endmodule
`default_nettype wire

FILE: tb/tb_resistive_touch_qualifier.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_resistive_touch_qualifier: self-checking bench for the touch qualifier
// Sends pen-down bursts, broken bursts and pen-up requests through the sample
// channel with random gaps and output stalls. A point tracker rebuilds the
// two-round trimmed means, the agreement test and the calibration for every
// accepted request, and each point taken from the block is checked against
// the oldest predicted point. Calibration is reloaded between phases.
// ----------------------------------------------------------------------------
module tb_resistive_touch_qualifier import rtq_pkg::*;;

	localparam int unsigned ROUND        = 5;
	localparam int unsigned DROP         = 1;
	localparam int          RAW_MAX      = (1 << RAW_W) - 1;
	localparam logic [RAW_W-1:0] RAW_FULL = '1;
	localparam int unsigned PHASES       = 6;
	localparam int unsigned PHASE_ITEMS  = 250;
	localparam int unsigned SETTLE_CYC   = 30;

	typedef struct packed {
		logic signed [PT_W-1:0] px;
		logic signed [PT_W-1:0] py;
		logic                   pressed;
		logic                   agreed;
	} touch_point_t;

	class point_tracker;
		rtq_cfg_t         cfg;
		logic [RAW_W-1:0] x_hist [ROUND];
		logic [RAW_W-1:0] y_hist [ROUND];
		logic [RAW_W-1:0] x_first;
		logic [RAW_W-1:0] y_first;
		int unsigned      taken;
		logic             pen_held;
		logic signed [PT_W-1:0] held_x;
		logic signed [PT_W-1:0] held_y;
		touch_point_t     expected_points [$];
		int unsigned      errors;

		function new();
			cfg = '{RST_ORIENTATION, RST_X_GAIN, RST_Y_GAIN, RST_X_OFFSET, RST_Y_OFFSET,
				RST_SCREEN_W, RST_SCREEN_H, RST_AGREE_TOL};
			foreach (x_hist[i]) begin
				x_hist[i] = '0;
				y_hist[i] = '0;
			end
			x_first  = '0;
			y_first  = '0;
			taken    = 0;
			pen_held = 1'b0;
			held_x   = '0;
			held_y   = '0;
			errors   = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
			case (idx)
				REG_ORIENTATION: cfg.orientation     = data[1:0];
				REG_X_GAIN:      cfg.x_gain          = data[16:0];
				REG_Y_GAIN:      cfg.y_gain          = data[16:0];
				REG_X_OFFSET:    cfg.x_offset        = data[10:0];
				REG_Y_OFFSET:    cfg.y_offset        = data[10:0];
				REG_SCREEN_W:    cfg.screen_width    = data[11:0];
				REG_SCREEN_H:    cfg.screen_height   = data[11:0];
				REG_AGREE_TOL:   cfg.agree_tolerance = data[12:0];
				default: ;
			endcase
		endfunction

		function int unsigned trimmed_round_mean(bit vertical);
			logic [RAW_W-1:0] srt [ROUND];
			logic [RAW_W-1:0] v;
			int j;
			int unsigned cut, total;
			for (int i = 0; i < ROUND; i++)
				srt[i] = vertical ? y_hist[i] : x_hist[i];
			for (int i = 1; i < ROUND; i++) begin
				v = srt[i];
				j = i;
				while (j > 0 && srt[j-1] > v) begin
					srt[j] = srt[j-1];
					j--;
				end
				srt[j] = v;
			end
			cut = DROP;
			if (2 * cut >= ROUND)
				cut = (ROUND - 1) / 2;
			total = 0;
			for (int i = cut; i < ROUND - cut; i++)
				total += 32'(srt[i]);
			return total / (ROUND - 2 * cut);
		endfunction

		function bit within_tol(int unsigned a, int unsigned b);
			int unsigned d;
			d = (a > b) ? a - b : b - a;
			return d < 32'(cfg.agree_tolerance);
		endfunction

		function logic signed [PT_W-1:0] to_screen(logic signed [16:0] gain, int unsigned mean,
			logic signed [10:0] off, logic [11:0] size, bit mirror);
			longint v, q;
			v = longint'(gain) * longint'(mean) + longint'(off) * 65536;
			if (mirror)
				v = longint'(size) * 65536 - v;
			q = v / 65536;
			if (q > 32767)
				q = 32767;
			if (q < -32768)
				q = -32768;
			return q[PT_W-1:0];
		endfunction

		function void take_sample(logic pen, logic [RAW_W-1:0] x, logic [RAW_W-1:0] y);
			int unsigned pos, xm2, ym2, xm, ym;
			logic agreed;
			bit mirror, swap;
			agreed = 1'b0;
			if (!pen) begin
				pen_held = 1'b0;
				taken    = 0;
			end else begin
				pos         = taken % ROUND;
				pen_held    = 1'b1;
				x_hist[pos] = x;
				y_hist[pos] = y;
				taken++;
				if (taken == ROUND) begin
					x_first = RAW_W'(trimmed_round_mean(1'b0));
					y_first = RAW_W'(trimmed_round_mean(1'b1));
					return;
				end
				if (taken < 2 * ROUND)
					return;
				taken = 0;
				xm2 = trimmed_round_mean(1'b0);
				ym2 = trimmed_round_mean(1'b1);
				if (within_tol(32'(x_first), xm2) && within_tol(32'(y_first), ym2)) begin
					xm     = (32'(x_first) + xm2) / 2;
					ym     = (32'(y_first) + ym2) / 2;
					mirror = cfg.orientation[0];
					swap   = cfg.orientation[1];
					held_x = to_screen(cfg.x_gain, swap ? ym : xm, cfg.x_offset,
						cfg.screen_width, mirror);
					held_y = to_screen(cfg.y_gain, swap ? xm : ym, cfg.y_offset,
						cfg.screen_height, mirror);
					agreed = 1'b1;
				end
			end
			expected_points.push_back('{held_x, held_y, pen_held, agreed});
		endfunction

		function void compare_field(string name, int want, int seen);
			if (want != seen) begin
				errors++;
				$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, seen);
			end
		endfunction

		function void check_point(touch_point_t seen);
			touch_point_t want;
			if (expected_points.size() == 0) begin
				errors++;
				$display("%0t: unexpected point, expected none, got x=%0d y=%0d p=%0b a=%0b",
					$time, seen.px, seen.py, seen.pressed, seen.agreed);
				return;
			end
			want = expected_points.pop_front();
			compare_field("point_x", int'(want.px), int'(seen.px));
			compare_field("point_y", int'(want.py), int'(seen.py));
			compare_field("pressed", int'(want.pressed), int'(seen.pressed));
			compare_field("agreed", int'(want.agreed), int'(seen.agreed));
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	bit                   quiet_src;
	bit                   quiet_sink;
	int unsigned          sent;
	point_tracker         tracker;

	rtq_sample_if sample_ch ();
	rtq_point_if  point_ch ();

	resistive_touch_qualifier i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample_in (sample_ch),
		.point_out (point_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#3000000;
		$display("resistive_touch_qualifier verification failed");
		$finish;
	end

	function automatic int unsigned idle_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [RAW_W-1:0] near_value(logic [RAW_W-1:0] base, int spread);
		int v;
		v = int'(base) + int'($urandom_range(0, 2 * spread)) - spread;
		if (v < 0)
			v = 0;
		if (v > RAW_MAX)
			v = RAW_MAX;
		return v[RAW_W-1:0];
	endfunction

	function automatic logic [RAW_W-1:0] any_raw();
		return RAW_W'($urandom_range(0, RAW_MAX));
	endfunction

	task automatic send_sample(logic pen, logic [RAW_W-1:0] x, logic [RAW_W-1:0] y);
		int unsigned gap;
		@(negedge clk);
		gap = quiet_src ? 0 : idle_len();
		if (gap != 0) begin
			sample_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		sample_ch.valid    <= 1'b1;
		sample_ch.pen_down <= pen;
		sample_ch.x_raw    <= x;
		sample_ch.y_raw    <= y;
		@(posedge clk);
		while (!sample_ch.ready)
			@(posedge clk);
		tracker.take_sample(pen, x, y);
		sent++;
	endtask

	task automatic settle();
		@(negedge clk);
		sample_ch.valid <= 1'b0;
		while (tracker.expected_points.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		tracker.set_reg(idx, data);
	endtask

	task automatic apply_setting(int k);
		rtq_cfg_t c;
		c.orientation     = 2'($urandom_range(0, 3));
		c.x_gain          = 17'($urandom);
		c.y_gain          = 17'($urandom);
		c.x_offset        = 11'($urandom);
		c.y_offset        = 11'($urandom);
		c.screen_width    = 12'($urandom_range(0, 4095));
		c.screen_height   = 12'($urandom_range(0, 4095));
		c.agree_tolerance = 13'($urandom_range(1, 600));
		case (k)
			1: c = '{2'd0, 17'sd65535, -17'sd65536, 11'sd1023, -11'sd1024, 12'd4095, 12'd0,
				13'd8191};
			2: c = '{2'd3, -17'sd65536, 17'sd65535, -11'sd1024, 11'sd1023, 12'd0, 12'd4095,
				13'd1};
			3: c.agree_tolerance = 13'd0;
			default: ;
		endcase
		write_reg(REG_ORIENTATION, CFG_W'(c.orientation));
		write_reg(REG_X_GAIN, CFG_W'(c.x_gain));
		write_reg(REG_Y_GAIN, CFG_W'(c.y_gain));
		write_reg(REG_X_OFFSET, CFG_W'(c.x_offset));
		write_reg(REG_Y_OFFSET, CFG_W'(c.y_offset));
		write_reg(REG_SCREEN_W, CFG_W'(c.screen_width));
		write_reg(REG_SCREEN_H, CFG_W'(c.screen_height));
		write_reg(REG_AGREE_TOL, CFG_W'(c.agree_tolerance));
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic run_gesture();
		int unsigned r, bursts, cut;
		int spread;
		logic [RAW_W-1:0] bx, by;
		r          = $urandom_range(0, 99);
		quiet_src  = ($urandom_range(0, 5) == 0);
		quiet_sink = ($urandom_range(0, 5) == 0);
		if (r < 12) begin
			repeat ($urandom_range(1, 12))
				send_sample(1'($urandom_range(0, 1)), any_raw(), any_raw());
			return;
		end
		case ($urandom_range(0, 9))
			0, 1:    spread = 0;
			2, 3, 4, 5, 6: spread = $urandom_range(1, 40);
			7, 8:    spread = $urandom_range(41, 400);
			default: spread = RAW_MAX;
		endcase
		bx = ($urandom_range(0, 9) == 0) ? ($urandom_range(0, 1) ? RAW_FULL : '0)
			: any_raw();
		by = ($urandom_range(0, 9) == 0) ? ($urandom_range(0, 1) ? RAW_FULL : '0)
			: any_raw();
		bursts = $urandom_range(1, 4);
		cut    = (r < 24) ? $urandom_range(1, 2 * ROUND * bursts - 1) : 0;
		for (int n = 1; n <= 2 * ROUND * bursts; n++) begin
			if (n == cut)
				break;
			send_sample(1'b1, near_value(bx, spread), near_value(by, spread));
		end
		send_sample(1'b0, any_raw(), any_raw());
	endtask

	initial begin
		int unsigned stall_left;
		point_ch.ready <= 1'b0;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (stall_left != 0 && !quiet_sink) begin
				point_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				point_ch.ready <= 1'b1;
				if (!quiet_sink && $urandom_range(0, 2) == 0)
					stall_left = idle_len();
			end
			@(posedge clk);
			if (point_ch.valid && point_ch.ready)
				tracker.check_point('{point_ch.point_x, point_ch.point_y, point_ch.pressed,
					point_ch.agreed});
		end
	end

	initial begin
		int unsigned target;
		tracker             = new();
		sent                = 0;
		quiet_src           = 1'b0;
		quiet_sink          = 1'b0;
		arst_n              = 1'b0;
		cfg_we             <= 1'b0;
		cfg_index          <= '0;
		cfg_data           <= '0;
		sample_ch.valid    <= 1'b0;
		sample_ch.pen_down <= 1'b0;
		sample_ch.x_raw    <= '0;
		sample_ch.y_raw    <= '0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		// pen up from reset, agreeing extremes, broken round, disagreeing rounds
		send_sample(1'b0, RAW_FULL, RAW_FULL);
		repeat (2 * ROUND) send_sample(1'b1, RAW_FULL, '0);
		repeat (3) send_sample(1'b1, '0, RAW_FULL);
		send_sample(1'b0, '0, '0);
		repeat (ROUND) send_sample(1'b1, '0, RAW_FULL);
		repeat (ROUND) send_sample(1'b1, RAW_FULL, RAW_FULL);
		settle();

		for (int k = 1; k <= PHASES; k++) begin
			apply_setting(k);
			target = sent + PHASE_ITEMS;
			while (sent < target)
				run_gesture();
			send_sample(1'b0, any_raw(), any_raw());
			settle();
		end

		if (tracker.errors == 0)
			$display("resistive_touch_qualifier verification clean");
		else
			$display("resistive_touch_qualifier verification failed");
		$finish;
	end

endmodule
`default_nettype wire
